/* hw/rtl/dsdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-sigma DoP framer package
// Shared payload types, DoP framing constants and the feedback code type.
// ----------------------------------------------------------------------------
package dsdf_pkg;

  // Width of one PCM sample field; the modulator full scale is 2^(SAMPLE_WIDTH-1).
  localparam int SAMPLE_WIDTH = 24;
  localparam int DOP_WIDTH    = 24;

  localparam logic [7:0] MARKER_EVEN = 8'h05;
  localparam logic [7:0] MARKER_ODD  = 8'hFA;
  localparam logic [7:0] BYTE_ONE    = 8'hFF;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;

  // Feedback held between requests: none after reset, else the last bit's sign.
  typedef enum logic [1:0] {
    FB_NONE  = 2'd0,
    FB_PLUS  = 2'd1,
    FB_MINUS = 2'd2
  } feedback_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;
  } sample_t;

  typedef struct packed {
    logic [DOP_WIDTH-1:0] left_dop_word;
    logic [DOP_WIDTH-1:0] right_dop_word;
    logic                 left_bit;
    logic                 right_bit;
  } frame_t;

  // Bits found by the two channel lanes for one request.
  typedef struct packed {
    logic left_bit;
    logic right_bit;
  } lane_bits_t;

  // Marker in the top byte, the data bit expanded to a byte twice below.
  function automatic logic [DOP_WIDTH-1:0] dop_word(input logic dbit,
                                                    input logic [7:0] marker);
    logic [7:0] data_byte;
    data_byte = dbit ? BYTE_ONE : BYTE_ZERO;
    return {marker, data_byte, data_byte};
  endfunction

endpackage

/* hw/rtl/dsdf_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-sigma DoP framer: channel lane
// Fourth-order modulator for one channel: four chained saturating integrators
// with one-bit feedback, advanced once per accepted request.
// ----------------------------------------------------------------------------
module dsdf_lane #(
  parameter int INTEGRATOR_WIDTH = 40
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    advance,
  input  logic signed [dsdf_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                                    dsd_bit
);

  localparam int SW = dsdf_pkg::SAMPLE_WIDTH;
  localparam int IW = INTEGRATOR_WIDTH;
  // Two guard bits hold the exact sum of three terms before clamping.
  localparam int EW = IW + 2;

  localparam logic signed [EW-1:0] FULL_SCALE = {{(EW-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}};
  localparam logic signed [IW-1:0] INTEG_MAX  = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] INTEG_MIN  = {1'b1, {(IW-1){1'b0}}};

  logic signed [IW-1:0] integ      [4];
  logic signed [IW-1:0] integ_next [4];
  dsdf_pkg::feedback_t  feedback;
  logic signed [EW-1:0] fb_term;

  function automatic logic signed [IW-1:0] saturate(input logic signed [EW-1:0] sum);
    logic [EW-IW:0] upper;
    upper = sum[EW-1:IW-1];
    if ((&upper) || !(|upper)) begin
      return sum[IW-1:0];
    end else if (sum[EW-1]) begin
      return INTEG_MIN;
    end else begin
      return INTEG_MAX;
    end
  endfunction

  always_comb begin
    case (feedback)
      dsdf_pkg::FB_NONE: fb_term = '0;
      dsdf_pkg::FB_PLUS: fb_term = FULL_SCALE;
      default:           fb_term = -FULL_SCALE;
    endcase
  end

  // The chain settles within the cycle; each stage feeds on its predecessor's new value.
  always_comb begin
    logic signed [EW-1:0] addend;
    logic signed [EW-1:0] old_ext;
    logic signed [EW-1:0] sum;
    for (int i = 0; i < 4; i++) begin
      if (i == 0) begin
        addend = {{(EW-SW){sample[SW-1]}}, sample};
      end else begin
        addend = {{(EW-IW){integ_next[i-1][IW-1]}}, integ_next[i-1]};
      end
      old_ext       = {{(EW-IW){integ[i][IW-1]}}, integ[i]};
      sum           = old_ext + addend - fb_term;
      integ_next[i] = saturate(sum);
    end
  end

  // A zero fourth integrator counts as non-negative and gives a one.
  assign dsd_bit = ~integ_next[3][IW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        integ[i] <= '0;
      end
      feedback <= dsdf_pkg::FB_NONE;
    end else if (advance) begin
      for (int i = 0; i < 4; i++) begin
        integ[i] <= integ_next[i];
      end
      feedback <= dsd_bit ? dsdf_pkg::FB_PLUS : dsdf_pkg::FB_MINUS;
    end
  end

endmodule

/* hw/rtl/dsdf_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-sigma DoP framer: merge and output stage
// Combines the lane bits with the alternating marker into DoP words and holds
// results in an output register backed by a skid register.
// ----------------------------------------------------------------------------
module dsdf_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  dsdf_pkg::lane_bits_t lane_bits,
  output logic                 take_ready,
  output dsdf_pkg::frame_t     frame,
  output logic                 frame_valid,
  input  logic                 frame_ready
);

  logic             marker_phase;
  dsdf_pkg::frame_t new_frame;
  logic [7:0]       marker;
  dsdf_pkg::frame_t skid;
  logic             skid_valid;

  always_comb begin
    marker                   = marker_phase ? dsdf_pkg::MARKER_ODD : dsdf_pkg::MARKER_EVEN;
    new_frame.left_dop_word  = dsdf_pkg::dop_word(lane_bits.left_bit, marker);
    new_frame.right_dop_word = dsdf_pkg::dop_word(lane_bits.right_bit, marker);
    new_frame.left_bit       = lane_bits.left_bit;
    new_frame.right_bit      = lane_bits.right_bit;
  end

  // Ready comes from a register, so the upstream path never sees frame_ready.
  assign take_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_phase <= 1'b0;
      frame_valid  <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (advance) begin
        marker_phase <= ~marker_phase;
      end
      if (advance) begin
        if (!frame_valid || frame_ready) begin
          frame_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (frame_valid && frame_ready) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          frame_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!frame_valid || frame_ready) begin
        frame <= new_frame;
      end else begin
        skid <= new_frame;
      end
    end else if (frame_valid && frame_ready && skid_valid) begin
      frame <= skid;
    end
  end

endmodule

/* hw/rtl/delta_sigma_dop_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-sigma DoP framer
// Stereo fourth-order one-bit delta-sigma modulator with DoP word framing.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload
//   --------  ---------------------------  ------------------------------------
//   sample    sample_valid / sample_ready  left_sample, right_sample (Q1.23)
//   frame     frame_valid / frame_ready    left/right DoP words and bits
//
// One request is taken per clock cycle while sample_ready is high; its frame is
// registered. The four chained integrator adds of each lane set the cycle time.
// Reset clears the integrators, the feedback and the marker phase, so the first
// frame after reset carries marker 0x05.
// When frame_ready is held low, one further request is caught in the skid
// register and sample_ready then drops until the skid register drains.
//
// The two channels run as identical lanes side by side. The merge stage joins
// their bits with the shared marker, which alternates between 0x05 and 0xFA on
// every frame, and expands each bit into the two data bytes of its DoP word.
// ----------------------------------------------------------------------------
module delta_sigma_dop_framer #(
  parameter int INTEGRATOR_WIDTH = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  dsdf_pkg::sample_t sample,
  output logic              frame_valid,
  input  logic              frame_ready,
  output dsdf_pkg::frame_t  frame
);

  // Lanes and marker phase all move on the same accepted request.
  logic                 advance;
  dsdf_pkg::lane_bits_t lane_bits;

  assign advance = sample_valid && sample_ready;

  dsdf_lane #(
    .INTEGRATOR_WIDTH(INTEGRATOR_WIDTH)
  ) u_lane_left (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (sample.left_sample),
    .dsd_bit (lane_bits.left_bit)
  );

  dsdf_lane #(
    .INTEGRATOR_WIDTH(INTEGRATOR_WIDTH)
  ) u_lane_right (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (sample.right_sample),
    .dsd_bit (lane_bits.right_bit)
  );

  // The merge stage owns the output register, so it also decides readiness.
  dsdf_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .lane_bits   (lane_bits),
    .take_ready  (sample_ready),
    .frame       (frame),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready)
  );

endmodule

/* hw/rtl/dsdf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-sigma DoP framer: port checker
// Watches the top-level ports for framing consistency and request flow.
// ----------------------------------------------------------------------------
module dsdf_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input dsdf_pkg::sample_t sample,
  input logic              frame_valid,
  input logic              frame_ready,
  input dsdf_pkg::frame_t  frame
);

  logic [7:0] left_marker;
  logic [7:0] right_marker;

  assign left_marker  = frame.left_dop_word[23:16];
  assign right_marker = frame.right_dop_word[23:16];

  // A pending frame is not withdrawn before it is taken.
  assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> frame_valid && $stable(frame))
    else $error("frame withdrawn or changed while stalled");

  // Reset leaves no frame pending and the block ready for a request.
  assert property (@(posedge clk) rst |=> !frame_valid && sample_ready)
    else $error("state after reset is not empty");

  // After every accepted request a frame is pending in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> frame_valid)
    else $error("accepted request produced no frame");

  // Both data bytes of each word mirror that channel's bit.
  assert property (@(posedge clk) disable iff (rst)
    frame_valid |->
      frame.left_dop_word[15:8] == {8{frame.left_bit}} &&
      frame.left_dop_word[7:0] == {8{frame.left_bit}} &&
      frame.right_dop_word[15:8] == {8{frame.right_bit}} &&
      frame.right_dop_word[7:0] == {8{frame.right_bit}})
    else $error("DoP data bytes disagree with the modulator bit");

  // Both channels share one legal marker per frame.
  assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> left_marker == right_marker &&
      (left_marker == dsdf_pkg::MARKER_EVEN || left_marker == dsdf_pkg::MARKER_ODD))
    else $error("DoP marker is illegal or differs between channels");

  logic unused_sample;
  assign unused_sample = ^sample;

endmodule

bind delta_sigma_dop_framer dsdf_checker u_dsdf_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .sample       (sample),
  .frame_valid  (frame_valid),
  .frame_ready  (frame_ready),
  .frame        (frame)
);

/* test/delta_sigma_dop_framer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-sigma DoP framer testbench
// Streams stereo PCM requests through the framer under random back-pressure
// and compares each frame with a typed-in one or an in-bench model of both lanes.
// ----------------------------------------------------------------------------
module delta_sigma_dop_framer_tb;

  localparam int ACC_W         = 40;
  localparam int RANDOM_ITEMS  = 630;
  localparam int PRESSURE_AT   = 250;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;

  localparam logic signed [63:0] ACC_MAX    = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam logic signed [63:0] ACC_MIN    = -ACC_MAX - 64'sd1;
  localparam logic signed [63:0] FULL_SCALE = 64'sd1 <<< (dsdf_pkg::SAMPLE_WIDTH - 1);

  localparam logic [dsdf_pkg::SAMPLE_WIDTH-1:0] PCM_MAX =
    {1'b0, {(dsdf_pkg::SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [dsdf_pkg::SAMPLE_WIDTH-1:0] PCM_MIN =
    {1'b1, {(dsdf_pkg::SAMPLE_WIDTH-1){1'b0}}};

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum int {
    LANE_LEFT  = 0,
    LANE_RIGHT = 1
  } lane_e;

  // Shapes of PCM content used by the random segments.
  typedef enum int {
    SHAPE_WIDE  = 0,
    SHAPE_QUIET = 1,
    SHAPE_DC    = 2,
    SHAPE_RAIL  = 3,
    SHAPE_SWING = 4
  } pcm_shape_e;

  // One row of the directed table. Where fixed is set, want holds the frame
  // typed in by hand; otherwise the lane model supplies the expectation.
  typedef struct packed {
    dsdf_pkg::sample_t pcm;
    logic              fixed;
    dsdf_pkg::frame_t  want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  dsdf_pkg::sample_t sample = '0;
  logic              frame_valid;
  logic              frame_ready = 1'b0;
  dsdf_pkg::frame_t  frame;

  // Travel with the payload so that the checker knows which rows are fixed.
  logic             has_golden = 1'b0;
  dsdf_pkg::frame_t golden_frame = '0;

  // Lane model state: four integrators and the held feedback per channel,
  // plus the shared marker phase.
  acc_t                lane_acc [2][4];
  dsdf_pkg::feedback_t lane_fb [2];
  logic                marker_odd;

  dsdf_pkg::frame_t pending_frames[$];
  int     requests_taken = 0;
  int     frames_seen = 0;
  int     failures = 0;
  int     clamp_events = 0;
  int     input_stall_cycles = 0;
  int     longest_hold = 0;
  int     sender_calm = 0;
  int     sink_calm = 0;
  logic   squeeze = 1'b0;
  logic   pressure_done = 1'b0;

  delta_sigma_dop_framer dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact sum of three terms, held within the signed integrator range.
  function automatic acc_t clamp_sum(acc_t prev, logic signed [63:0] addend,
                                     logic signed [63:0] fb_value);
    logic signed [63:0] wide_prev;
    logic signed [63:0] total;
    wide_prev = 64'(prev);
    total = wide_prev + addend - fb_value;
    if (total > ACC_MAX) begin
      clamp_events++;
      return ACC_MAX[ACC_W-1:0];
    end
    if (total < ACC_MIN) begin
      clamp_events++;
      return ACC_MIN[ACC_W-1:0];
    end
    return total[ACC_W-1:0];
  endfunction

  // Runs one lane of the modulator for one sample and returns its new bit.
  function automatic logic advance_lane(lane_e lane,
                                        logic signed [dsdf_pkg::SAMPLE_WIDTH-1:0] pcm);
    logic signed [63:0] fb_value;
    logic signed [63:0] addend;
    logic               positive;
    if (lane_fb[lane] == dsdf_pkg::FB_PLUS) begin
      fb_value = FULL_SCALE;
    end else if (lane_fb[lane] == dsdf_pkg::FB_NONE) begin
      fb_value = 64'sd0;
    end else begin
      fb_value = -FULL_SCALE;
    end
    addend = 64'(pcm);
    for (int k = 0; k < 4; k++) begin
      lane_acc[lane][k] = clamp_sum(lane_acc[lane][k], addend, fb_value);
      addend = 64'(lane_acc[lane][k]);
    end
    // A fourth integrator of exactly zero counts as non-negative.
    positive = ~lane_acc[lane][3][ACC_W-1];
    lane_fb[lane] = positive ? dsdf_pkg::FB_PLUS : dsdf_pkg::FB_MINUS;
    return positive;
  endfunction

  function automatic dsdf_pkg::frame_t predict_frame(dsdf_pkg::sample_t pcm);
    dsdf_pkg::frame_t f;
    logic [7:0]       marker;
    logic             lbit;
    logic             rbit;
    lbit = advance_lane(LANE_LEFT, pcm.left_sample);
    rbit = advance_lane(LANE_RIGHT, pcm.right_sample);
    marker = marker_odd ? dsdf_pkg::MARKER_ODD : dsdf_pkg::MARKER_EVEN;
    f.left_dop_word  = {marker, {8{lbit}}, {8{lbit}}};
    f.right_dop_word = {marker, {8{rbit}}, {8{rbit}}};
    f.left_bit       = lbit;
    f.right_bit      = rbit;
    marker_odd = ~marker_odd;
    return f;
  endfunction

  function automatic void report_mismatch(string field,
                                          logic [dsdf_pkg::DOP_WIDTH-1:0] want_v,
                                          logic [dsdf_pkg::DOP_WIDTH-1:0] got_v);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("frame %0d: %s expected %h, got %h", frames_seen, field, want_v, got_v);
    end
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long one, and
  // occasional calm stretches with no gaps at all.
  function automatic int draw_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [dsdf_pkg::SAMPLE_WIDTH-1:0] draw_pcm(
      pcm_shape_e shape, logic [dsdf_pkg::SAMPLE_WIDTH-1:0] level);
    logic [31:0] raw;
    int          noise;
    raw = $urandom;
    case (shape)
      SHAPE_QUIET: begin
        noise = int'($urandom_range(0, 65535)) - 32768;
        return noise[dsdf_pkg::SAMPLE_WIDTH-1:0];
      end
      SHAPE_DC: begin
        noise = int'($urandom_range(0, 511)) - 256;
        return level + noise[dsdf_pkg::SAMPLE_WIDTH-1:0];
      end
      SHAPE_RAIL: begin
        return level[dsdf_pkg::SAMPLE_WIDTH-1] ? PCM_MIN : PCM_MAX;
      end
      SHAPE_SWING: begin
        return raw[0] ? PCM_MIN : PCM_MAX;
      end
      default: begin
        return raw[dsdf_pkg::SAMPLE_WIDTH-1:0];
      end
    endcase
  endfunction

  function automatic stim_row_t row(logic [dsdf_pkg::SAMPLE_WIDTH-1:0] left,
                                    logic [dsdf_pkg::SAMPLE_WIDTH-1:0] right,
                                    logic fixed, dsdf_pkg::frame_t want);
    stim_row_t r;
    r.pcm.left_sample  = left;
    r.pcm.right_sample = right;
    r.fixed            = fixed;
    r.want             = want;
    return r;
  endfunction

  // Holds the request until it is taken. Valid is only raised here, so it stays
  // high across back-to-back requests.
  task automatic offer(dsdf_pkg::sample_t pcm, logic fixed, dsdf_pkg::frame_t want);
    sample_valid <= 1'b1;
    sample       <= pcm;
    has_golden   <= fixed;
    golden_frame <= want;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      sample_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Prediction and checking share one clocked block, so a request taken at an
  // edge is queued before any frame released at that same edge is compared.
  always @(posedge clk) begin : scoreboard
    dsdf_pkg::frame_t want;
    if (!rst) begin
      if (sample_valid && !sample_ready) begin
        input_stall_cycles++;
      end
      if (sample_valid && sample_ready) begin
        want = predict_frame(sample);
        if (has_golden) begin
          want = golden_frame;
        end
        pending_frames.push_back(want);
        requests_taken++;
      end
      if (frame_valid && frame_ready) begin
        if (pending_frames.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("frame %0d arrived with no request outstanding: %h", frames_seen, frame);
          end
        end else begin
          want = pending_frames.pop_front();
          if (frame.left_dop_word !== want.left_dop_word) begin
            report_mismatch("left_dop_word", want.left_dop_word, frame.left_dop_word);
          end
          if (frame.right_dop_word !== want.right_dop_word) begin
            report_mismatch("right_dop_word", want.right_dop_word, frame.right_dop_word);
          end
          if (frame.left_bit !== want.left_bit) begin
            report_mismatch("left_bit",
                            {{(dsdf_pkg::DOP_WIDTH-1){1'b0}}, want.left_bit},
                            {{(dsdf_pkg::DOP_WIDTH-1){1'b0}}, frame.left_bit});
          end
          if (frame.right_bit !== want.right_bit) begin
            report_mismatch("right_bit",
                            {{(dsdf_pkg::DOP_WIDTH-1){1'b0}}, want.right_bit},
                            {{(dsdf_pkg::DOP_WIDTH-1){1'b0}}, frame.right_bit});
          end
        end
        frames_seen++;
      end
    end
  end

  // Frame sink. It stalls at random, and once, part way through the run, it
  // holds ready low long enough for the skid register to fill and the block
  // to push back on its sample side.
  initial begin : frame_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && frames_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        squeeze = 1'b1;
        frame_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze = 1'b0;
        if (HOLD_CYCLES > longest_hold) longest_hold = HOLD_CYCLES;
      end else begin
        stall = draw_pause(sink_calm);
        if (stall > 0) begin
          frame_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          if (stall > longest_hold) longest_hold = stall;
        end
      end
      frame_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles with %0d frames still outstanding",
             cycles, pending_frames.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t                         directed[$];
    dsdf_pkg::sample_t                 pcm;
    pcm_shape_e                        left_shape;
    pcm_shape_e                        right_shape;
    logic [dsdf_pkg::SAMPLE_WIDTH-1:0] left_level;
    logic [dsdf_pkg::SAMPLE_WIDTH-1:0] right_level;
    int                                seg_len;
    int                                sent_random;

    for (int lane = 0; lane < 2; lane++) begin
      for (int k = 0; k < 4; k++) begin
        lane_acc[lane][k] = '0;
      end
      lane_fb[lane] = dsdf_pkg::FB_NONE;
    end
    marker_odd = 1'b0;

    // The first two rows are known by inspection. Straight after reset a
    // silent input leaves every integrator at zero, which gives bit one on both
    // lanes under the first marker. The next row pits full scale against the
    // positive feedback, so all four integrators go negative on both lanes
    // and the marker has moved on.
    directed.push_back(row('0, '0, 1'b1,
                           {dsdf_pkg::MARKER_EVEN, 16'hFFFF,
                            dsdf_pkg::MARKER_EVEN, 16'hFFFF, 1'b1, 1'b1}));
    directed.push_back(row(PCM_MAX, PCM_MIN, 1'b1,
                           {dsdf_pkg::MARKER_ODD, 16'h0000,
                            dsdf_pkg::MARKER_ODD, 16'h0000, 1'b0, 1'b0}));
    directed.push_back(row(PCM_MIN, PCM_MAX, 1'b0, '0));
    directed.push_back(row(24'h000001, 24'hFFFFFF, 1'b0, '0));
    directed.push_back(row(24'hFFFFFF, 24'h000001, 1'b0, '0));
    directed.push_back(row(24'h555555, 24'hAAAAAA, 1'b0, '0));
    directed.push_back(row(24'hAAAAAA, 24'h555555, 1'b0, '0));
    directed.push_back(row(24'h400000, 24'hC00000, 1'b0, '0));
    directed.push_back(row(24'h7FFFFE, 24'h800001, 1'b0, '0));
    directed.push_back(row('0, '0, 1'b0, '0));
    // Runs at the rails drive the unstable loop towards integrator clamping.
    for (int n = 0; n < 6; n++) begin
      directed.push_back(row(PCM_MAX, PCM_MAX, 1'b0, '0));
    end
    for (int n = 0; n < 6; n++) begin
      directed.push_back(row(PCM_MIN, PCM_MIN, 1'b0, '0));
    end
    directed.push_back(row(PCM_MAX, PCM_MIN, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      offer(directed[i].pcm, directed[i].fixed, directed[i].want);
      idle_sender(draw_pause(sender_calm));
    end

    // Random segments, each with its own content shape per channel. Rail
    // segments are long enough to let the integrators run into their limits.
    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      left_shape  = pcm_shape_e'($urandom_range(0, 4));
      right_shape = pcm_shape_e'($urandom_range(0, 4));
      left_level  = draw_pcm(SHAPE_WIDE, '0);
      right_level = draw_pcm(SHAPE_WIDE, '0);
      seg_len     = $urandom_range(15, 90);
      for (int n = 0; n < seg_len && sent_random < RANDOM_ITEMS; n++) begin
        pcm.left_sample  = draw_pcm(left_shape, left_level);
        pcm.right_sample = draw_pcm(right_shape, right_level);
        offer(pcm, 1'b0, '0);
        sent_random++;
        idle_sender(squeeze ? 0 : draw_pause(sender_calm));
      end
    end
    sample_valid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d sample pairs sent (%0d from the table), %0d frames compared",
             requests_taken, directed.size(), frames_seen);
    $display("%0d clamped integrator updates, %0d cycles of input back-pressure, %s %0d cycles",
             clamp_events, input_stall_cycles, "longest sink hold-off", longest_hold);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures in total", failures);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/dsdf_pkg.sv
hw/rtl/dsdf_lane.sv
hw/rtl/dsdf_merge.sv
hw/rtl/delta_sigma_dop_framer.sv
hw/rtl/dsdf_checker.sv
test/delta_sigma_dop_framer_tb.sv
